[src/ctpc_pkg.sv]
`timescale 1ns / 1ps

package ctpc_pkg;

    localparam int SPEED_W = 12;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int GAIN_W  = 8;
    localparam int THR_W   = 8;
    localparam int INDEX_W = 3;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST      = 8'd100;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST     = 8'd1;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST     = 8'd5;
    localparam logic [GAIN_W-1:0] GAS_INCREMENT_RST  = 8'd2;
    localparam logic [THR_W-1:0]  THROTTLE_LIMIT_RST = 8'd80;

    typedef enum logic [INDEX_W-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_GAS_INCREMENT  = 3'd3,
        REG_THROTTLE_LIMIT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic               gas_pressed;
        logic               brake_pressed;
        logic               cruise_level;
        logic [SPEED_W-1:0] speed;
    } sample_t;

    typedef struct packed {
        logic [THR_W-1:0]   throttle_out;
        logic               cruise_on;
        logic [SPEED_W-1:0] target_speed;
    } result_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] gas_increment;
        logic [THR_W-1:0]  throttle_limit;
    } cfg_t;

endpackage

[src/ctpc_cfg_regs.sv]
`timescale 1ns / 1ps

module ctpc_cfg_regs
    import ctpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]  cfg_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PROP_GAIN:      cfg_next.prop_gain      = cfg_data;
                REG_INTEG_GAIN:     cfg_next.integ_gain     = cfg_data;
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = cfg_data;
                REG_GAS_INCREMENT:  cfg_next.gas_increment  = cfg_data;
                REG_THROTTLE_LIMIT: cfg_next.throttle_limit = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= PROP_GAIN_RST;
            cfg_reg.integ_gain     <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain     <= DERIV_GAIN_RST;
            cfg_reg.gas_increment  <= GAS_INCREMENT_RST;
            cfg_reg.throttle_limit <= THROTTLE_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/ctpc_pid.sv]
`timescale 1ns / 1ps

module ctpc_pid
    import ctpc_pkg::*;
#(
    parameter int INTEG_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [SPEED_W-1:0] target,
    input  logic [SPEED_W-1:0] speed,
    input  cfg_t               cfg,
    output logic [THR_W-1:0]   throttle
);

    localparam int SUM_W = INTEG_BITS + 11;
    localparam int P_W   = ERR_W + GAIN_W + 1;
    localparam int D_W   = ERR_W + GAIN_W + 2;
    localparam int I_W   = INTEG_BITS + GAIN_W + 1;

    localparam logic signed [INTEG_BITS-1:0] INTEG_MAX = {1'b0, {(INTEG_BITS-1){1'b1}}};
    localparam logic signed [INTEG_BITS-1:0] INTEG_MIN = {1'b1, {(INTEG_BITS-1){1'b0}}};

    logic signed [INTEG_BITS-1:0] integral_reg;
    logic signed [INTEG_BITS-1:0] integral_next;
    logic signed [ERR_W-1:0]      last_err_reg;

    logic signed [ERR_W-1:0]    err;
    logic signed [INTEG_BITS:0] acc_wide;
    logic signed [ERR_W:0]      der;
    logic signed [P_W-1:0]      p_term;
    logic signed [I_W-1:0]      i_term;
    logic signed [D_W-1:0]      d_term;
    logic signed [SUM_W-1:0]    sum;

    always_comb
    begin
        err = $signed({1'b0, target}) - $signed({1'b0, speed});
        acc_wide = $signed({integral_reg[INTEG_BITS-1], integral_reg})
                 + $signed({{(INTEG_BITS+1-ERR_W){err[ERR_W-1]}}, err});
        if (acc_wide[INTEG_BITS] != acc_wide[INTEG_BITS-1])
        begin
            integral_next = acc_wide[INTEG_BITS] ? INTEG_MIN : INTEG_MAX;
        end
        else
        begin
            integral_next = acc_wide[INTEG_BITS-1:0];
        end
        der = $signed({err[ERR_W-1], err}) - $signed({last_err_reg[ERR_W-1], last_err_reg});

        p_term = $signed({1'b0, cfg.prop_gain}) * err;
        i_term = $signed({1'b0, cfg.integ_gain}) * integral_next;
        d_term = $signed({1'b0, cfg.deriv_gain}) * der;

        sum = $signed({{(SUM_W-P_W){p_term[P_W-1]}}, p_term})
            + $signed({{(SUM_W-I_W){i_term[I_W-1]}}, i_term})
            + $signed({{(SUM_W-D_W){d_term[D_W-1]}}, d_term});

        if (sum[SUM_W-1])
        begin
            throttle = '0;
        end
        else if (sum > $signed({{(SUM_W-THR_W){1'b0}}, cfg.throttle_limit}))
        begin
            throttle = cfg.throttle_limit;
        end
        else
        begin
            throttle = sum[THR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            last_err_reg <= '0;
        end
        else if (en)
        begin
            integral_reg <= integral_next;
            last_err_reg <= err;
        end
    end

endmodule

[src/ctpc_mode.sv]
`timescale 1ns / 1ps

module ctpc_mode
    import ctpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  sample_t            word,
    input  cfg_t               cfg,
    input  logic [THR_W-1:0]   pid_throttle,
    output logic               pid_en,
    output logic [SPEED_W-1:0] target,
    output result_t            result
);

    logic               cruise_reg;
    logic               cruise_next;
    logic               button_reg;
    logic [SPEED_W-1:0] target_reg;
    logic [SPEED_W-1:0] target_next;
    logic [THR_W-1:0]   throttle_reg;
    logic [THR_W-1:0]   throttle_next;

    logic               toggle;
    logic               pid_sel;
    logic [THR_W:0]     gas_sum;

    always_comb
    begin
        toggle      = button_reg & ~word.cruise_level;
        target_next = toggle ? word.speed : target_reg;
        cruise_next = (toggle ^ cruise_reg) & ~word.brake_pressed;
        pid_sel     = ~word.brake_pressed & ~word.gas_pressed & cruise_next;
        gas_sum     = {1'b0, throttle_reg} + {1'b0, cfg.gas_increment};

        if (word.brake_pressed)
        begin
            throttle_next = '0;
        end
        else if (word.gas_pressed)
        begin
            throttle_next = (gas_sum > {1'b0, cfg.throttle_limit}) ? cfg.throttle_limit
                                                                   : gas_sum[THR_W-1:0];
        end
        else if (pid_sel)
        begin
            throttle_next = pid_throttle;
        end
        else
        begin
            throttle_next = '0;
        end
    end

    assign pid_en = step & pid_sel;
    assign target = target_next;

    assign result.throttle_out = throttle_next;
    assign result.cruise_on    = cruise_next;
    assign result.target_speed = target_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_reg   <= 1'b0;
            button_reg   <= 1'b1;
            target_reg   <= '0;
            throttle_reg <= '0;
        end
        else if (step)
        begin
            cruise_reg   <= cruise_next;
            button_reg   <= word.cruise_level;
            target_reg   <= target_next;
            throttle_reg <= throttle_next;
        end
    end

endmodule

[src/cruise_throttle_pid_controller.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Word
// sample    in         sample_valid / sample_ready  sample_t (pedals, button, speed)
// result    out        result_valid / result_ready  result_t (throttle, mode, target)
// cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A sample word is registered, processed by the mode logic and the PID datapath
// combinationally, and lands in the result register; one word per cycle is sustained
// while result_ready is high. A word goes from the input stage to the result register.
// The PID multipliers and the integral saturation set the critical path.
// Reset clears the control state, restores the register defaults and empties both stages.
// A stalled result register holds the input stage, which then stops taking words.

module cruise_throttle_pid_controller
    import ctpc_pkg::*;
#(
    parameter int INTEG_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  sample_t            sample,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]  cfg_data
);

    cfg_t               cfg;
    logic               stage_valid_reg;
    sample_t            stage_word_reg;
    logic               out_valid_reg;
    result_t            out_word_reg;
    logic               step;
    logic               pid_en;
    logic [SPEED_W-1:0] target;
    logic [THR_W-1:0]   pid_throttle;
    result_t            result_next;

    assign step         = stage_valid_reg & (~out_valid_reg | result_ready);
    assign sample_ready = ~stage_valid_reg | step;
    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    ctpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctpc_mode u_mode (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .word         (stage_word_reg),
        .cfg          (cfg),
        .pid_throttle (pid_throttle),
        .pid_en       (pid_en),
        .target       (target),
        .result       (result_next)
    );

    ctpc_pid #(
        .INTEG_BITS (INTEG_BITS)
    ) u_pid (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pid_en),
        .target   (target),
        .speed    (stage_word_reg.speed),
        .cfg      (cfg),
        .throttle (pid_throttle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                stage_valid_reg <= sample_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            stage_word_reg <= sample;
        end
        if (step)
        begin
            out_word_reg <= result_next;
        end
    end

`ifndef SYNTH
    a_throttle_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_word_reg.throttle_out <= cfg.throttle_limit)
        else $error("throttle above limit");

    a_brake_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && stage_word_reg.brake_pressed
        |=> out_word_reg.throttle_out == '0 && !out_word_reg.cruise_on)
        else $error("brake did not clear throttle and cruise");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step && !stage_word_reg.gas_pressed && !result_next.cruise_on
        |=> out_word_reg.throttle_out == '0)
        else $error("throttle not zero outside gas and cruise");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !step |=> stage_valid_reg && $stable(stage_word_reg))
        else $error("input stage lost a word under stall");

    a_pid_only_cruise: assert property (@(posedge clk) disable iff (!rst_n)
        pid_en |-> step && result_next.cruise_on && !stage_word_reg.gas_pressed)
        else $error("PID state updated outside a cruise tick");
`endif

endmodule
